// File: src/tsvf_pkg.sv
`default_nettype none

package tsvf_pkg;

	// Coefficient format shared by the sequencer and the serial multiplier.
	localparam int COEF_WIDTH = 24;
	localparam int GAIN_SHIFT = 18;
	localparam int NORM_SHIFT = 23;

	// Multiplier bits retired per clock.
	localparam int DIGIT_BITS = 2;

	typedef struct packed {
		logic start;
		logic norm_sel;
	} mul_ctl_t;

endpackage

`default_nettype wire

// File: src/tsvf_serial_mul.sv
`default_nettype none

module tsvf_serial_mul #(
	parameter int WIDE_WIDTH = 40
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  tsvf_pkg::mul_ctl_t                   ctl,
	input  wire signed [WIDE_WIDTH-1:0]          operand,
	input  wire        [tsvf_pkg::COEF_WIDTH-1:0] coef,
	output logic                                 done,
	output logic signed [WIDE_WIDTH-1:0]         product
);

	import tsvf_pkg::*;

	localparam int WW    = WIDE_WIDTH;
	localparam int PW    = WW + COEF_WIDTH;
	localparam int RW    = PW - GAIN_SHIFT;
	localparam int STEPS = COEF_WIDTH / DIGIT_BITS;
	localparam int CW    = $clog2(STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ROUND,
		ST_SAT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic                neg_q;
	logic                norm_q;
	logic [WW-1:0]       mag_q;
	logic [PW-1:0]       acc_q;
	logic [RW-1:0]       r_q;
	logic                done_q;
	logic signed [WW-1:0] product_q;

	logic [WW+1:0]       sum;
	logic [RW-1:0]       rnd_base;
	logic                rnd_bit;
	logic                too_big;

	// The low end of the accumulator holds the coefficient; each step consumes
	// its two lowest bits and shifts the partial product in from the top.
	always_comb begin
		sum = {2'b00, acc_q[PW-1:COEF_WIDTH]}
			+ (acc_q[0] ? {2'b00, mag_q} : {(WW+2){1'b0}})
			+ (acc_q[1] ? {1'b0, mag_q, 1'b0} : {(WW+2){1'b0}});
		rnd_base = norm_q ? RW'(acc_q >> NORM_SHIFT) : RW'(acc_q >> GAIN_SHIFT);
		rnd_bit  = norm_q ? acc_q[NORM_SHIFT-1] : acc_q[GAIN_SHIFT-1];
		too_big  = |r_q[RW-1:WW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			neg_q     <= 1'b0;
			norm_q    <= 1'b0;
			mag_q     <= '0;
			acc_q     <= '0;
			r_q       <= '0;
			done_q    <= 1'b0;
			product_q <= '0;
		end else begin
			done_q <= (state_q == ST_SAT);
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						neg_q   <= operand[WW-1];
						norm_q  <= ctl.norm_sel;
						mag_q   <= operand[WW-1] ? WW'(-operand) : WW'(operand);
						acc_q   <= {{WW{1'b0}}, coef};
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					acc_q <= {sum, acc_q[COEF_WIDTH-1:DIGIT_BITS]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(STEPS - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					// Rounding the magnitude gives halves away from zero.
					r_q     <= rnd_base + RW'(rnd_bit);
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (too_big) begin
						product_q <= neg_q ? {1'b1, {(WW-1){1'b0}}}
							: {1'b0, {(WW-1){1'b1}}};
					end else begin
						product_q <= neg_q ? -$signed(r_q[WW-1:0])
							: $signed(r_q[WW-1:0]);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign product = product_q;

endmodule

`default_nettype wire

// File: src/tpt_svf_lowpass_top.sv
`default_nettype none

// Second-order trapezoidal state-variable lowpass filter. Each request carries
// one signed sample together with its own gain g (Q6.18) and normalizer d
// (Q1.23) and yields one saturated lowpass sample. The three products of the
// update run one after another on a single multiplier that retires two
// coefficient bits per clock. Each product goes through start, 12 steps,
// rounding, saturation and hand-back. A request is handled by forming the
// first difference, running the three products and storing the result. The
// input is ready again in the same cycle as the result becomes valid, and no
// new request is taken while one is in flight. A finished result sits in an
// output register, and the next request is taken while it waits to be read;
// that request then holds in its final state until the output register
// is free.
module tpt_svf_lowpass_top #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int STATE_WIDTH  = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   sample_valid,
	output logic                                  sample_stall,
	input  wire signed [SAMPLE_WIDTH-1:0]         sample_in,
	input  wire        [tsvf_pkg::COEF_WIDTH-1:0] coef_gain,
	input  wire        [tsvf_pkg::COEF_WIDTH-1:0] coef_norm,
	output logic                                  lowpass_valid,
	input  wire                                   lowpass_stall,
	output logic signed [SAMPLE_WIDTH-1:0]        lowpass_out
);

	import tsvf_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int TW = STATE_WIDTH;
	localparam int WW = STATE_WIDTH + 8;
	localparam int XW = WW + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic signed [SW-1:0] x_q;
	logic [COEF_WIDTH-1:0] g_q;
	logic [COEF_WIDTH-1:0] d_q;
	logic [COEF_WIDTH-1:0] coef_q;
	logic signed [WW-1:0] op_q;
	logic signed [TW-1:0] s1_q;
	logic signed [TW-1:0] s2_q;
	logic signed [WW-1:0] lp_q;
	logic signed [WW-1:0] v_q;
	mul_ctl_t             mul_ctl_q;
	logic                 out_valid_q;
	logic signed [SW-1:0] out_q;

	logic                 mul_done;
	logic signed [WW-1:0] mul_product;

	function automatic logic signed [WW-1:0] sat_wide(input logic signed [XW-1:0] v);
		if (&v[XW-1:WW-1] || ~|v[XW-1:WW-1]) begin
			return v[WW-1:0];
		end
		return v[XW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
	endfunction

	function automatic logic signed [TW-1:0] sat_state(input logic signed [XW-1:0] v);
		if (&v[XW-1:TW-1] || ~|v[XW-1:TW-1]) begin
			return v[TW-1:0];
		end
		return v[XW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
	endfunction

	function automatic logic signed [SW-1:0] sat_out(input logic signed [XW-1:0] v);
		if (&v[XW-1:SW-1] || ~|v[XW-1:SW-1]) begin
			return v[SW-1:0];
		end
		return v[XW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
	endfunction

	tsvf_serial_mul #(
		.WIDE_WIDTH(WW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl_q),
		.operand (op_q),
		.coef    (coef_q),
		.done    (mul_done),
		.product (mul_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			g_q         <= '0;
			d_q         <= '0;
			coef_q      <= '0;
			op_q        <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
			lp_q        <= '0;
			v_q         <= '0;
			mul_ctl_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// A product is started after the first difference and after each of
			// the first two products completes.
			mul_ctl_q.start <= (state_q == ST_ERR)
				|| (mul_done && (state_q == ST_MUL1 || state_q == ST_MUL2));
			out_valid_q <= (out_valid_q && lowpass_stall)
				|| (state_q == ST_FIN && (!out_valid_q || !lowpass_stall));
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						x_q     <= sample_in;
						g_q     <= coef_gain;
						d_q     <= coef_norm;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					op_q               <= sat_wide(XW'(x_q) - XW'(s2_q));
					coef_q             <= g_q;
					mul_ctl_q.norm_sel <= 1'b0;
					state_q            <= ST_MUL1;
				end
				ST_MUL1: begin
					if (mul_done) begin
						op_q               <= sat_wide(XW'(mul_product) + XW'(s1_q));
						coef_q             <= d_q;
						mul_ctl_q.norm_sel <= 1'b1;
						state_q            <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					// The product is the bandpass value.
					if (mul_done) begin
						s1_q <= sat_state(XW'(mul_product) + XW'(mul_product)
							- XW'(s1_q));
						op_q               <= mul_product;
						coef_q             <= g_q;
						mul_ctl_q.norm_sel <= 1'b0;
						state_q            <= ST_MUL3;
					end
				end
				ST_MUL3: begin
					if (mul_done) begin
						v_q     <= mul_product;
						lp_q    <= sat_wide(XW'(mul_product) + XW'(s2_q));
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !lowpass_stall) begin
						s2_q    <= sat_state(XW'(lp_q) + XW'(v_q));
						out_q   <= sat_out(XW'(lp_q));
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_stall  = (state_q != ST_IDLE);
	assign lowpass_valid = out_valid_q;
	assign lowpass_out   = out_q;

endmodule

`default_nettype wire
